### sv/delayed_note_scheduler_core_assert.svh
// ---------------------------------------------------------------------------
// delayed_note_scheduler_core assertion macros
// concurrent checks on clk, disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef DELAYED_NOTE_SCHEDULER_CORE_ASSERT_SVH
`define DELAYED_NOTE_SCHEDULER_CORE_ASSERT_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define DNS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dns check failed");

// condition holds at every edge out of reset
`define DNS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("dns check failed");

`else

`define DNS_ASSERT_IMPL(lbl, ante, cons)
`define DNS_ASSERT_ALWAYS(lbl, cond)

`endif

`endif

### sv/dns_pkg.sv
// ---------------------------------------------------------------------------
// dns_pkg
// shared constants, codes and types of the delayed note scheduler
// ---------------------------------------------------------------------------
package dns_pkg;

  localparam int POOL_SLOTS  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_TICK     = 2'd1,
    OP_CLEAR    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_SCHEDULED = 2'd0,
    KIND_DROPPED   = 2'd1,
    KIND_RELEASED  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_EVAL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [3:0]  track;
    logic [3:0]  channel;
    logic [15:0] duration;
    logic [31:0] destination;
  } payload_t;

  typedef struct packed {
    kind_t    kind;
    payload_t payload;
    logic     last;
  } result_t;

  typedef struct packed {
    logic              sched;
    logic              clear;
    logic              tick_start;
    logic [SLOT_W-1:0] rd_idx;
    logic [SLOT_W-1:0] idx;
    logic              upd_delay;
    logic              zero_delay;
    logic              load_rel;
    logic              seal;
    logic              seal_last;
  } cmd_t;

  typedef struct packed {
    logic act;
    logic due;
    logic pend_valid;
    logic pend_done;
    logic pend_open;
  } status_t;

endpackage

### sv/dns_datapath.sv
// ---------------------------------------------------------------------------
// dns_datapath
// slot memories, active bits, pending result and output register
// ---------------------------------------------------------------------------
module dns_datapath (
  input  logic             clk,
  input  logic             rst,
  input  dns_pkg::cmd_t    cmd,
  output dns_pkg::status_t status,
  input  logic [6:0]       note,
  input  logic [6:0]       velocity,
  input  logic [3:0]       track,
  input  logic [3:0]       channel,
  input  logic [15:0]      duration,
  input  logic [15:0]      delay_ms,
  input  logic [31:0]      destination,
  input  logic [15:0]      elapsed_ms,
  output logic             out_valid,
  input  logic             out_ready,
  output dns_pkg::result_t out_res
);

  logic [dns_pkg::POOL_SLOTS-1:0] active;
  logic [15:0]                    delay_mem [dns_pkg::POOL_SLOTS];
  dns_pkg::payload_t              payload_mem [dns_pkg::POOL_SLOTS];
  logic [15:0]                    rd_delay;
  dns_pkg::payload_t              rd_payload;
  logic [15:0]                    dec;

  logic [dns_pkg::SLOT_W-1:0]     free_idx;
  logic                           full;
  logic                           sched_wr;
  logic                           dly_we;
  logic [dns_pkg::SLOT_W-1:0]     wr_idx;
  logic [15:0]                    dly_wdata;
  dns_pkg::payload_t              sched_payload;

  dns_pkg::result_t               pend;
  logic                           pend_valid;
  logic                           pend_done;
  logic                           out_free;
  logic                           move_out;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = dns_pkg::POOL_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_idx = dns_pkg::SLOT_W'(i);
        full     = 1'b0;
      end
    end
  end

  assign sched_wr = cmd.sched && !full;

  always_comb begin
    sched_payload.note        = note;
    sched_payload.velocity    = velocity;
    sched_payload.track       = track;
    sched_payload.channel     = channel;
    sched_payload.duration    = duration;
    sched_payload.destination = destination;
  end

  assign dly_we = sched_wr || cmd.upd_delay || cmd.zero_delay;
  assign wr_idx = cmd.sched ? free_idx : cmd.idx;

  always_comb begin
    if (cmd.sched) begin
      dly_wdata = delay_ms;
    end else if (cmd.upd_delay) begin
      dly_wdata = rd_delay - dec;
    end else begin
      dly_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      delay_mem[wr_idx] <= dly_wdata;
    end
    if (sched_wr) begin
      payload_mem[free_idx] <= sched_payload;
    end
    rd_delay   <= delay_mem[cmd.rd_idx];
    rd_payload <= payload_mem[cmd.rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      dec <= (elapsed_ms == 16'd0) ? 16'd1 : elapsed_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.clear) begin
      active <= '0;
    end else if (sched_wr) begin
      active[free_idx] <= 1'b1;
    end else if (cmd.load_rel) begin
      active[cmd.idx] <= 1'b0;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign move_out = pend_valid && pend_done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_done  <= 1'b0;
    end else if (cmd.sched) begin
      pend_valid <= 1'b1;
      pend_done  <= 1'b1;
    end else if (cmd.load_rel) begin
      pend_valid <= 1'b1;
      pend_done  <= 1'b0;
    end else if (move_out) begin
      pend_valid <= 1'b0;
    end else if (cmd.seal && pend_valid) begin
      pend_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched) begin
      pend.kind    <= full ? dns_pkg::KIND_DROPPED : dns_pkg::KIND_SCHEDULED;
      pend.payload <= '0;
      pend.last    <= 1'b1;
    end else if (cmd.load_rel) begin
      pend.kind    <= dns_pkg::KIND_RELEASED;
      pend.payload <= rd_payload;
      pend.last    <= 1'b0;
    end else if (cmd.seal && pend_valid && !pend_done) begin
      pend.last <= cmd.seal_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      out_res <= pend;
    end
  end

  always_comb begin
    status.act        = active[cmd.idx];
    status.due        = rd_delay <= dec;
    status.pend_valid = pend_valid;
    status.pend_done  = pend_done;
    status.pend_open  = !pend_valid || (pend_done && out_free);
  end

`include "delayed_note_scheduler_core_assert.svh"

  `DNS_ASSERT_IMPL(a_rel_into_open, cmd.load_rel, !pend_valid || move_out)
  `DNS_ASSERT_IMPL(a_sched_empty, cmd.sched, !pend_valid)
  `DNS_ASSERT_IMPL(a_open_is_release, pend_valid && !pend_done,
                   pend.kind == dns_pkg::KIND_RELEASED && !pend.last)

endmodule

### sv/dns_ctrl.sv
// ---------------------------------------------------------------------------
// dns_ctrl
// operation decode and slot sweep sequencer
// ---------------------------------------------------------------------------
module dns_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       operation,
  input  dns_pkg::status_t status,
  output dns_pkg::cmd_t    cmd
);

  dns_pkg::state_t             state;
  dns_pkg::state_t             state_next;
  logic [dns_pkg::SLOT_W-1:0]  idx;
  logic [dns_pkg::SLOT_W-1:0]  idx_next;
  logic [dns_pkg::RCNT_W-1:0]  rel_cnt;
  logic [dns_pkg::RCNT_W-1:0]  rel_cnt_next;
  logic                        advance;
  logic                        last_slot;

  assign last_slot = idx == dns_pkg::SLOT_W'(dns_pkg::POOL_SLOTS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dns_pkg::ST_IDLE;
      idx     <= '0;
      rel_cnt <= '0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      rel_cnt <= rel_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    rel_cnt_next = rel_cnt;
    in_ready     = 1'b0;
    advance      = 1'b0;
    cmd          = '0;
    cmd.idx      = idx;
    cmd.rd_idx   = idx;

    unique case (state)
      dns_pkg::ST_IDLE: begin
        in_ready = !status.pend_valid;
        if (in_valid && in_ready) begin
          case (operation)
            dns_pkg::OP_SCHEDULE: cmd.sched = 1'b1;
            dns_pkg::OP_CLEAR:    cmd.clear = 1'b1;
            dns_pkg::OP_TICK: begin
              cmd.tick_start = 1'b1;
              state_next     = dns_pkg::ST_START;
            end
            default: ;
          endcase
        end
      end
      dns_pkg::ST_START: begin
        cmd.rd_idx   = '0;
        idx_next     = '0;
        rel_cnt_next = '0;
        state_next   = dns_pkg::ST_EVAL;
      end
      dns_pkg::ST_EVAL: begin
        if (!status.act) begin
          advance = 1'b1;
        end else if (!status.due) begin
          cmd.upd_delay = 1'b1;
          advance       = 1'b1;
        end else if (rel_cnt == dns_pkg::RCNT_W'(dns_pkg::MAX_RESULTS)) begin
          cmd.zero_delay = 1'b1;
          advance        = 1'b1;
        end else if (status.pend_open) begin
          cmd.load_rel = 1'b1;
          rel_cnt_next = rel_cnt + 1'b1;
          advance      = 1'b1;
        end else if (status.pend_valid && !status.pend_done) begin
          cmd.seal = 1'b1;
        end
        if (advance) begin
          if (last_slot) begin
            cmd.rd_idx = '0;
            state_next = dns_pkg::ST_FIN;
          end else begin
            cmd.rd_idx = idx + 1'b1;
            idx_next   = idx + 1'b1;
          end
        end
      end
      dns_pkg::ST_FIN: begin
        cmd.seal      = 1'b1;
        cmd.seal_last = 1'b1;
        state_next    = dns_pkg::ST_IDLE;
      end
      default: state_next = dns_pkg::ST_IDLE;
    endcase
  end

`include "delayed_note_scheduler_core_assert.svh"

  `DNS_ASSERT_ALWAYS(a_rel_cnt_bound, rel_cnt <= dns_pkg::RCNT_W'(dns_pkg::MAX_RESULTS))
  `DNS_ASSERT_IMPL(a_idle_sealed, state == dns_pkg::ST_IDLE && status.pend_valid,
                   status.pend_done)

endmodule

### sv/delayed_note_scheduler_core.sv
// ---------------------------------------------------------------------------
// delayed_note_scheduler_core
// pool of delayed note-on slots: schedule, tick release and clear
// ---------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_ready  | operation, note ... elapsed_ms
//   out     | out_valid / out_ready| kind, out_note ... out_destination, last
//
// clear and reserved codes are done in the idle state; a schedule's result
// moves to the output register before the next item is taken
// a tick walks every slot from START through EVAL to FIN:
// a release waits in a pending register until the next one or the sweep end
// sets its last flag, and out stalls hold the sweep there
// reset clears the active bits, the sequencer and both result valid flags
//
module delayed_note_scheduler_core (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [6:0]  note,
  input  logic [6:0]  velocity,
  input  logic [3:0]  track,
  input  logic [3:0]  channel,
  input  logic [15:0] duration,
  input  logic [15:0] delay_ms,
  input  logic [31:0] destination,
  input  logic [15:0] elapsed_ms,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [6:0]  out_note,
  output logic [6:0]  out_velocity,
  output logic [3:0]  out_track,
  output logic [3:0]  out_channel,
  output logic [15:0] out_duration,
  output logic [31:0] out_destination,
  output logic        last
);

  dns_pkg::cmd_t    cmd;
  dns_pkg::status_t status;
  dns_pkg::result_t out_res;

  // sequencer: decodes the operation and walks the slots on a tick
  dns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  // slot storage, compare and subtract, result registers
  dns_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .note        (note),
    .velocity    (velocity),
    .track       (track),
    .channel     (channel),
    .duration    (duration),
    .delay_ms    (delay_ms),
    .destination (destination),
    .elapsed_ms  (elapsed_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (out_res)
  );

  // unpack the output register onto the result ports
  assign kind            = out_res.kind;
  assign out_note        = out_res.payload.note;
  assign out_velocity    = out_res.payload.velocity;
  assign out_track       = out_res.payload.track;
  assign out_channel     = out_res.payload.channel;
  assign out_duration    = out_res.payload.duration;
  assign out_destination = out_res.payload.destination;
  assign last            = out_res.last;

endmodule
